@@ rtl/column_degree_variation_coefficient_assert.svh @@
// Assertion macros for the column degree variation block.
// CDVC_ASSERT checks on every rising clock edge outside reset; CDVC_ASSERT_RST also checks in reset.
`ifndef COLUMN_DEGREE_VARIATION_COEFFICIENT_ASSERT_SVH
`define COLUMN_DEGREE_VARIATION_COEFFICIENT_ASSERT_SVH

`ifndef SYNTHESIS
`define CDVC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cdvc: assertion failed");
`define CDVC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cdvc: reset assertion failed");
`else
`define CDVC_ASSERT(label, prop)
`define CDVC_ASSERT_RST(label, prop)
`endif

`endif

@@ rtl/cdvc_pkg.sv @@
package cdvc_pkg;

    localparam int PW          = 20;
    localparam int MAX_COLUMNS = 65536;
    localparam int FB          = 16;

    localparam int CW     = $clog2(MAX_COLUMNS + 1);
    localparam int SW     = 2 * PW;
    localparam int AW     = SW + CW;
    localparam int VW     = AW + 2 * FB;
    localparam int QW     = (VW + 1) / 2;
    localparam int RADW   = 2 * QW;
    localparam int OUTW   = 24;
    localparam int STEP_W = $clog2(QW);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_COLUMNS = 2'd1;
    localparam logic [1:0] ST_ZERO_SUM   = 2'd2;
    localparam logic [1:0] ST_DECREASE   = 2'd3;

    typedef struct packed {
        logic take;
        logic start_mul;
        logic mul_step;
        logic start_root;
        logic root_step;
        logic start_div;
        logic div_step;
        logic load_out;
    } cdvc_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic skip;
    } cdvc_stat_t;

endpackage

@@ rtl/cdvc_datapath.sv @@
module cdvc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cdvc_pkg::cdvc_cmd_t          cmd,
    output cdvc_pkg::cdvc_stat_t         stat,
    input  logic [19:0]                  col_pointer,
    output logic [cdvc_pkg::OUTW-1:0]    variation_q8_16,
    output logic [1:0]                   status,
    output logic [cdvc_pkg::CW-1:0]      columns_seen
);

    localparam int PW   = cdvc_pkg::PW;
    localparam int CW   = cdvc_pkg::CW;
    localparam int SW   = cdvc_pkg::SW;
    localparam int AW   = cdvc_pkg::AW;
    localparam int QW   = cdvc_pkg::QW;
    localparam int RADW = cdvc_pkg::RADW;
    localparam int OUTW = cdvc_pkg::OUTW;
    localparam int FB   = cdvc_pkg::FB;

    // accumulation state
    logic          have_prev_reg;
    logic          dec_reg;
    logic          v1_reg;
    logic          v2_reg;
    logic [PW-1:0] prev_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] sum_reg;
    logic [SW-1:0] sq_sum_reg;
    logic [PW-1:0] deg_reg;
    logic [SW-1:0] sq_reg;

    // math units
    logic [AW-1:0]   mul_acc_reg;
    logic [AW-1:0]   mul_addend_reg;
    logic [CW-1:0]   mul_n_reg;
    logic [SW-1:0]   sum_pow_reg;
    logic [RADW-1:0] rad_reg;
    logic [QW:0]     rem_reg;
    logic [QW-1:0]   root_reg;
    logic [QW-1:0]   dq_reg;
    logic [PW-1:0]   drem_reg;
    logic [QW-1:0]   quo_reg;

    logic [OUTW-1:0] var_out_reg;
    logic [1:0]      status_out_reg;
    logic [CW-1:0]   cols_out_reg;

    logic [PW-1:0] ptr;
    logic [PW-1:0] deg;
    logic [PW:0]   sum_add;
    logic [SW:0]   sq_add;
    logic [AW-1:0] variance;
    logic [QW+2:0] rem_t;
    logic [QW+2:0] trial;
    logic [PW:0]   div_t;
    logic [1:0]    status_code;
    logic [OUTW-1:0] ratio_sat;

    assign ptr     = col_pointer[PW-1:0];
    assign deg     = ptr - prev_reg;
    assign sum_add = {1'b0, sum_reg} + {1'b0, deg};
    assign sq_add  = {1'b0, sq_sum_reg} + {1'b0, sq_reg};

    always_comb
    begin
        if (count_reg == '0)
        begin
            status_code = cdvc_pkg::ST_NO_COLUMNS;
        end
        else if (dec_reg)
        begin
            status_code = cdvc_pkg::ST_DECREASE;
        end
        else if (sum_reg == '0)
        begin
            status_code = cdvc_pkg::ST_ZERO_SUM;
        end
        else
        begin
            status_code = cdvc_pkg::ST_OK;
        end
    end

    assign stat.pipe_busy = v1_reg | v2_reg;
    assign stat.skip      = (status_code != cdvc_pkg::ST_OK);

    assign variance = (mul_acc_reg > AW'(sum_pow_reg)) ? mul_acc_reg - AW'(sum_pow_reg) : '0;
    assign rem_t    = {rem_reg, rad_reg[RADW-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign div_t    = {drem_reg, dq_reg[QW-1]};
    assign ratio_sat = (quo_reg[QW-1:OUTW] != '0) ? '1 : quo_reg[OUTW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            dec_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            prev_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            sq_sum_reg    <= '0;
        end
        else if (cmd.load_out)
        begin
            // run is complete: clear for the next frame
            have_prev_reg <= 1'b0;
            dec_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            prev_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            sq_sum_reg    <= '0;
        end
        else
        begin
            v1_reg <= 1'b0;
            if (cmd.take)
            begin
                if (have_prev_reg)
                begin
                    if (ptr < prev_reg)
                    begin
                        dec_reg <= 1'b1;
                    end
                    else if (count_reg < CW'(cdvc_pkg::MAX_COLUMNS))
                    begin
                        count_reg <= count_reg + 1'b1;
                        sum_reg   <= sum_add[PW] ? '1 : sum_add[PW-1:0];
                        v1_reg    <= 1'b1;
                    end
                end
                prev_reg      <= ptr;
                have_prev_reg <= 1'b1;
            end
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                sq_sum_reg <= sq_add[SW] ? '1 : sq_add[SW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            deg_reg <= deg;
        end
        if (v1_reg)
        begin
            sq_reg <= SW'(deg_reg) * SW'(deg_reg);
        end
    end

    // shift-add multiplier, bit-pair square root, restoring divider
    always_ff @(posedge clk)
    begin
        if (cmd.start_mul)
        begin
            mul_acc_reg    <= '0;
            mul_addend_reg <= AW'(sq_sum_reg);
            mul_n_reg      <= count_reg;
            sum_pow_reg    <= SW'(sum_reg) * SW'(sum_reg);
        end
        else if (cmd.mul_step)
        begin
            if (mul_n_reg[0])
            begin
                mul_acc_reg <= mul_acc_reg + mul_addend_reg;
            end
            mul_addend_reg <= mul_addend_reg << 1;
            mul_n_reg      <= mul_n_reg >> 1;
        end

        if (cmd.start_root)
        begin
            rad_reg  <= RADW'({variance, {(2 * FB){1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            if (rem_t >= trial)
            begin
                rem_reg  <= (QW + 1)'(rem_t - trial);
                root_reg <= {root_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_t[QW:0];
                root_reg <= {root_reg[QW-2:0], 1'b0};
            end
            rad_reg <= rad_reg << 2;
        end

        if (cmd.start_div)
        begin
            dq_reg   <= root_reg;
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_t >= {1'b0, sum_reg})
            begin
                drem_reg <= PW'(div_t - {1'b0, sum_reg});
                quo_reg  <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= div_t[PW-1:0];
                quo_reg  <= {quo_reg[QW-2:0], 1'b0};
            end
            dq_reg <= dq_reg << 1;
        end

        if (cmd.load_out)
        begin
            var_out_reg    <= stat.skip ? '0 : ratio_sat;
            status_out_reg <= status_code;
            cols_out_reg   <= count_reg;
        end
    end

    assign variation_q8_16 = var_out_reg;
    assign status          = status_out_reg;
    assign columns_seen    = cols_out_reg;

endmodule

@@ rtl/cdvc_ctrl.sv @@
module cdvc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output cdvc_pkg::cdvc_cmd_t   cmd,
    input  cdvc_pkg::cdvc_stat_t  stat
);

    localparam int STEP_W = cdvc_pkg::STEP_W;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_DRAIN,
        S_MUL,
        S_ROOT_LD,
        S_ROOT,
        S_DIV_LD,
        S_DIV,
        S_FINISH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.take       = s_tvalid && (state_reg == S_ACCUM);
        cmd.start_mul  = (state_reg == S_DRAIN) && !stat.pipe_busy && !stat.skip;
        cmd.mul_step   = (state_reg == S_MUL);
        cmd.start_root = (state_reg == S_ROOT_LD);
        cmd.root_step  = (state_reg == S_ROOT);
        cmd.start_div  = (state_reg == S_DIV_LD);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.load_out   = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_ACCUM:
            begin
                if (cmd.take && s_tlast)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    if (stat.skip)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_MUL;
                        cnt_next   = STEP_W'(cdvc_pkg::CW - 1);
                    end
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ROOT_LD;
                end
            end
            S_ROOT_LD:
            begin
                state_next = S_ROOT;
                cnt_next   = STEP_W'(cdvc_pkg::QW - 1);
            end
            S_ROOT:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DIV_LD;
                end
            end
            S_DIV_LD:
            begin
                state_next = S_DIV;
                cnt_next   = STEP_W'(cdvc_pkg::QW - 1);
            end
            S_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase

        // hold the result beat until it is taken
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_ACCUM;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_ACCUM);
    assign m_tvalid = m_tvalid_reg;

`include "column_degree_variation_coefficient_assert.svh"

    `CDVC_ASSERT(a_last_drains, (cmd.take && s_tlast) |=> (state_reg == S_DRAIN))
    `CDVC_ASSERT(a_pipe_idle_in_math, stat.pipe_busy |-> (state_reg == S_ACCUM || state_reg == S_DRAIN))
    `CDVC_ASSERT(a_mul_count, (state_reg == S_MUL) |-> (cnt_reg <= STEP_W'(cdvc_pkg::CW - 1)))
    `CDVC_ASSERT(a_load_shows, cmd.load_out |=> (m_tvalid_reg && state_reg == S_ACCUM))
    `CDVC_ASSERT_RST(a_reset_idle, !rst_n |=> (!m_tvalid_reg && state_reg == S_ACCUM))

endmodule

@@ rtl/column_degree_variation_coefficient.sv @@
// Coefficient of variation of the column degrees of a CSC matrix. Column-pointer entries stream
// in on the slave side, one beat per cycle, with tlast on the final entry; each entry after the
// first that adds a degree passes through a three-stage accumulate pipeline. After the final
// entry the block stops taking beats while the pipeline drains, then a bit-serial multiplier
// over the column count bits, a bit-pair square root and a restoring divider produce the
// Q8.16 result; when the status is not ok these are skipped and the result beat follows the
// drain. The result beat comes later if the previous result beat still waits on the master
// side.
// The next frame may start while that result beat still waits on the master side.
module column_degree_variation_coefficient (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // col_pointer[19:0], zero pad
    input  logic        s_tlast,   // last_entry
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // variation_q8_16[23:0], columns_seen[40:24], zero pad
    output logic [1:0]  m_tuser    // status
);

    cdvc_pkg::cdvc_cmd_t  cmd;
    cdvc_pkg::cdvc_stat_t stat;

    logic [cdvc_pkg::OUTW-1:0] variation_q8_16;
    logic [1:0]                status;
    logic [cdvc_pkg::CW-1:0]   columns_seen;

    cdvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cdvc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .col_pointer     (s_tdata[19:0]),
        .variation_q8_16 (variation_q8_16),
        .status          (status),
        .columns_seen    (columns_seen)
    );

    assign m_tdata = {7'b0, columns_seen, variation_q8_16};
    assign m_tuser = status;

endmodule

@@ bench/column_degree_variation_coefficient_check.sv @@
`timescale 1ns / 100ps

module column_degree_variation_coefficient_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int unsigned outstanding,
    output int unsigned failures
);

    typedef struct packed {
        logic [cdvc_pkg::OUTW-1:0] variation;
        logic [1:0]                status;
        logic [cdvc_pkg::CW-1:0]   columns;
    } cv_result_t;

    cv_result_t expected_cv[$];

    // running statistics of the frame in progress
    logic                    have_prev;
    logic [cdvc_pkg::PW-1:0] prev_ptr;
    logic [cdvc_pkg::CW-1:0] col_count;
    logic [cdvc_pkg::PW-1:0] deg_sum;
    logic [cdvc_pkg::SW-1:0] deg_sq_sum;
    logic                    drop_seen;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        failures++;
    endtask

    task automatic clear_frame();
        have_prev  = 1'b0;
        prev_ptr   = '0;
        col_count  = '0;
        deg_sum    = '0;
        deg_sq_sum = '0;
        drop_seen  = 1'b0;
    endtask

    // Largest r up to saturation with (r*sum)^2 <= spread * 2^(2*FB).
    function automatic logic [cdvc_pkg::OUTW-1:0] cv_q8_16(input logic [63:0] spread,
                                                           input logic [cdvc_pkg::PW-1:0] total);
        logic [127:0]              bound;
        logic [127:0]              term;
        logic [cdvc_pkg::OUTW-1:0] r;
        logic [cdvc_pkg::OUTW-1:0] cand;
        bound = {64'd0, spread} << (2 * cdvc_pkg::FB);
        r = '0;
        for (int b = cdvc_pkg::OUTW - 1; b >= 0; b--)
        begin
            cand = r | (cdvc_pkg::OUTW'(1) << b);
            term = 128'(cand) * 128'(total);
            if (term * term <= bound)
                r = cand;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        cv_result_t              want;
        logic [cdvc_pkg::PW-1:0] ptr;
        logic [cdvc_pkg::PW-1:0] deg;
        logic [cdvc_pkg::PW:0]   sum_ext;
        logic [cdvc_pkg::SW:0]   sq_ext;
        logic [63:0]             n_sq;
        logic [63:0]             sum_sq;
        if (!rst_n)
        begin
            clear_frame();
            expected_cv.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_cv.size() == 0)
                    report_mismatch("result beat with nothing pending", m_tdata, 0);
                else
                begin
                    want = expected_cv.pop_front();
                    if (m_tdata[23:0] !== want.variation)
                        report_mismatch("variation_q8_16", m_tdata[23:0], want.variation);
                    if (m_tdata[40:24] !== want.columns)
                        report_mismatch("columns_seen", m_tdata[40:24], want.columns);
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[47:41] !== '0)
                        report_mismatch("tdata pad", m_tdata[47:41], 0);
                end
            end

            if (s_tvalid && s_tready)
            begin
                ptr = s_tdata[cdvc_pkg::PW-1:0];
                if (have_prev)
                begin
                    if (ptr < prev_ptr)
                        drop_seen = 1'b1;
                    else if (col_count < cdvc_pkg::MAX_COLUMNS)
                    begin
                        deg = ptr - prev_ptr;
                        col_count++;
                        sum_ext = deg_sum + deg;
                        deg_sum = sum_ext[cdvc_pkg::PW] ? '1 : sum_ext[cdvc_pkg::PW-1:0];
                        sq_ext = deg_sq_sum + deg * deg;
                        deg_sq_sum = sq_ext[cdvc_pkg::SW] ? '1 : sq_ext[cdvc_pkg::SW-1:0];
                    end
                end
                prev_ptr  = ptr;
                have_prev = 1'b1;

                if (s_tlast)
                begin
                    want.variation = '0;
                    want.columns   = col_count;
                    if (col_count == 0)
                        want.status = cdvc_pkg::ST_NO_COLUMNS;
                    else if (drop_seen)
                        want.status = cdvc_pkg::ST_DECREASE;
                    else if (deg_sum == 0)
                        want.status = cdvc_pkg::ST_ZERO_SUM;
                    else
                    begin
                        n_sq   = col_count * deg_sq_sum;
                        sum_sq = deg_sum * deg_sum;
                        want.status    = cdvc_pkg::ST_OK;
                        // clamp a negative spread, only reachable after saturation
                        want.variation = cv_q8_16((n_sq > sum_sq) ? n_sq - sum_sq : 64'd0,
                                                  deg_sum);
                    end
                    expected_cv.push_back(want);
                    clear_frame();
                end
            end
            outstanding <= expected_cv.size();
        end
    end

endmodule

@@ bench/column_degree_variation_coefficient_test.sv @@
`timescale 1ns / 100ps

module column_degree_variation_coefficient_test;

    localparam int RANDOM_ENTRIES = 1250;
    localparam int PTR_MAX        = 20'hFFFFF;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    int unsigned outstanding;
    int unsigned failures;
    int          entries_sent   = 0;
    int          send_idle_pct  = 36;
    int          recv_idle_pct  = 73;

    always #1 clk = ~clk;

    column_degree_variation_coefficient i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    column_degree_variation_coefficient_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Hold the beat until the block takes it.
    task automatic send_entry(input logic [19:0] ptr, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, ptr};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        entries_sent++;
    endtask

    task automatic send_random_frame();
        int          kind;
        int          len;
        int          drop_at;
        int          step;
        int          next_ptr;
        logic [19:0] ptr;
        kind = $urandom_range(99);
        if (kind < 4)
            len = 1;
        else if ($urandom_range(9) == 0)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(2, 12);
        drop_at = (kind >= 88 && len > 1) ? $urandom_range(1, len - 1) : -1;
        ptr = ($urandom_range(3) == 0) ? 20'($urandom_range(0, PTR_MAX))
                                       : 20'($urandom_range(0, 4095));
        for (int i = 0; i < len; i++)
        begin
            if (i == drop_at)
            begin
                if (ptr != 0)
                    ptr = 20'($urandom_range(0, int'(ptr) - 1));
                else
                    ptr = 20'($urandom_range(1, PTR_MAX));
            end
            else if (i > 0)
            begin
                // zero-degree frames hit the zero-sum path
                if (kind >= 4 && kind < 10)
                    step = 0;
                else
                    case ($urandom_range(3))
                        0:       step = 0;
                        1:       step = $urandom_range(0, 15);
                        2:       step = $urandom_range(0, 4095);
                        default: step = $urandom_range(0, 'h3FFFF);
                    endcase
                next_ptr = int'(ptr) + step;
                ptr = (next_ptr > PTR_MAX) ? PTR_MAX[19:0] : next_ptr[19:0];
            end
            send_entry(ptr, i == len - 1);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // single entry frames: no columns
        send_entry(20'h00000, 1'b1);
        send_entry(20'hFFFFF, 1'b1);
        // ordinary frame with a zero degree
        send_entry(20'd0, 1'b0);
        send_entry(20'd3, 1'b0);
        send_entry(20'd3, 1'b0);
        send_entry(20'd10, 1'b1);
        // all degrees zero
        send_entry(20'd5, 1'b0);
        send_entry(20'd5, 1'b0);
        send_entry(20'd5, 1'b1);
        // pointer decreases
        send_entry(20'd10, 1'b0);
        send_entry(20'd4, 1'b0);
        send_entry(20'd20, 1'b1);
        // widest spread of degrees
        send_entry(20'h00000, 1'b0);
        send_entry(20'h00000, 1'b0);
        send_entry(20'h00000, 1'b0);
        send_entry(20'hFFFFF, 1'b1);
        // saturate both sums behind decreases
        send_entry(20'hFFFFF, 1'b0);
        send_entry(20'h00000, 1'b0);
        send_entry(20'hFFFFF, 1'b0);
        send_entry(20'h00000, 1'b0);
        send_entry(20'hFFFFF, 1'b1);
        // one full-range column
        send_entry(20'h00000, 1'b0);
        send_entry(20'hFFFFF, 1'b1);

        while (entries_sent < RANDOM_ENTRIES)
        begin
            if (entries_sent >= 2 * RANDOM_ENTRIES / 3)
                set_idling(0, 0);
            else if (entries_sent >= RANDOM_ENTRIES / 3)
                set_idling(73, 36);
            send_random_frame();
        end

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cdvc_pkg.sv
rtl/cdvc_datapath.sv
rtl/cdvc_ctrl.sv
rtl/column_degree_variation_coefficient.sv
bench/column_degree_variation_coefficient_check.sv
bench/column_degree_variation_coefficient_test.sv
